// File: rtl/core/mru_pkg.sv
// Shared types, codes and constants of the message rendezvous unit.
package mru_pkg;

	localparam int NPROC_DEF = 16;
	localparam int AW        = 6;

	localparam logic [4:0] PEER_ANY  = 5'd16;
	localparam logic [4:0] PEER_INT  = 5'd17;
	localparam logic [4:0] NONE_MARK = 5'd31;

	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_RECV = 2'd1;
	localparam logic [1:0] MODE_IRQ  = 2'd2;

	localparam logic [1:0] PM_IDLE = 2'd0;
	localparam logic [1:0] PM_SEND = 2'd1;
	localparam logic [1:0] PM_RECV = 2'd2;

	localparam logic [2:0] OC_BLOCKED   = 3'd0;
	localparam logic [2:0] OC_DELIVERED = 3'd1;
	localparam logic [2:0] OC_NOTICE    = 3'd2;
	localparam logic [2:0] OC_RECORDED  = 3'd3;
	localparam logic [2:0] OC_REJECTED  = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  caller;
		logic [4:0]  peer;
		logic [31:0] msg_ref;
	} req_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [31:0] copy_dst_ref;
		logic [31:0] copy_src_ref;
		logic [4:0]  msg_source;
		logic        woken_valid;
		logic [3:0]  woken_pid;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  target;
		logic [4:0]  wsrc;
		logic [31:0] ref_h;
		logic [4:0]  head;
		logic [4:0]  link;
		logic        intp;
	} rec_t;

	typedef struct packed {
		logic [AW-1:0] raddr;
		logic          we;
		logic [AW-1:0] waddr;
		rec_t          wdata;
	} cmd_t;

	localparam rec_t REC_RESET = '{mode: PM_IDLE, target: 4'd0, wsrc: NONE_MARK,
		ref_h: 32'd0, head: NONE_MARK, link: NONE_MARK, intp: 1'b0};

	localparam rsp_t RSP_REJECT = '{outcome: OC_REJECTED, copy_dst_ref: 32'd0,
		copy_src_ref: 32'd0, msg_source: 5'd0, woken_valid: 1'b0, woken_pid: 4'd0};

	localparam rsp_t RSP_BLOCKED = '{outcome: OC_BLOCKED, copy_dst_ref: 32'd0,
		copy_src_ref: 32'd0, msg_source: 5'd0, woken_valid: 1'b0, woken_pid: 4'd0};

	function automatic rec_t clear_rec(input rec_t r);
		rec_t o;
		o        = r;
		o.mode   = PM_IDLE;
		o.target = 4'd0;
		o.wsrc   = NONE_MARK;
		o.ref_h  = 32'd0;
		return o;
	endfunction

endpackage

// File: rtl/core/mru_store.sv
// Per-process rendezvous state: one write port, one registered read port.
module mru_store #(
	parameter int NPROC = mru_pkg::NPROC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mru_pkg::cmd_t cmd,
	output mru_pkg::rec_t rd
);
	import mru_pkg::*;

	localparam int IW = (NPROC > 1) ? $clog2(NPROC) : 1;

	rec_t mem_q [NPROC];
	rec_t rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPROC; i++) begin
				mem_q[i] <= REC_RESET;
			end
			rd_q <= REC_RESET;
		end else begin
			if (cmd.we) begin
				mem_q[cmd.waddr[IW-1:0]] <= cmd.wdata;
			end
			rd_q <= mem_q[cmd.raddr[IW-1:0]];
		end
	end

	assign rd = rd_q;

endmodule

// File: rtl/core/mru_ctrl.sv
// Request sequencer: decodes a request, walks sender lists, builds the result.
module mru_ctrl #(
	parameter int NPROC = mru_pkg::NPROC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mru_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mru_pkg::rsp_t rsp,
	output mru_pkg::cmd_t cmd,
	input  mru_pkg::rec_t rd
);
	import mru_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RC, S_RP, S_WALK, S_HEAD, S_RF, S_UH, S_UW, S_FIN
	} state_t;

	state_t     st_q, st_n;
	req_t       r_q, r_n;
	rec_t       c_q, c_n, p_q, p_n, w;
	logic [4:0] cur_q, cur_n, from_q, from_n, flink_q, flink_n;
	logic       any_q, any_n, vld_q, vld_n;
	rsp_t       pend_q, pend_n, rsp_q, rsp_n;
	logic [4:0] cid;

	assign cid       = {1'b0, r_q.caller};
	assign req_ready = (st_q == S_IDLE);
	assign rsp_valid = vld_q;
	assign rsp       = rsp_q;

	always_comb begin
		st_n    = st_q;
		r_n     = r_q;
		c_n     = c_q;
		p_n     = p_q;
		cur_n   = cur_q;
		from_n  = from_q;
		flink_n = flink_q;
		any_n   = any_q;
		pend_n  = pend_q;
		rsp_n   = rsp_q;
		vld_n   = vld_q;
		w       = rd;
		cmd     = '{raddr: '0, we: 1'b0, waddr: '0, wdata: rd};
		if (vld_q && rsp_ready) begin
			vld_n = 1'b0;
		end
		case (st_q)
			S_IDLE: begin
				if (req_valid) begin
					r_n = req;
					if (32'(req.caller) >= NPROC || req.mode == 2'd3) begin
						pend_n = RSP_REJECT;
						st_n   = S_FIN;
					end else begin
						cmd.raddr = AW'(req.caller);
						st_n      = S_RC;
					end
				end
			end
			S_RC: begin
				c_n    = rd;
				pend_n = RSP_REJECT;
				st_n   = S_FIN;
				cmd.waddr = AW'(r_q.caller);
				if (r_q.mode == MODE_IRQ) begin
					cmd.we = 1'b1;
					if (rd.mode == PM_RECV && (rd.wsrc == PEER_ANY || rd.wsrc == PEER_INT)) begin
						w      = clear_rec(rd);
						w.intp = 1'b0;
						pend_n = '{outcome: OC_NOTICE, copy_dst_ref: rd.ref_h, copy_src_ref: 32'd0,
							msg_source: PEER_INT, woken_valid: 1'b1, woken_pid: r_q.caller};
					end else begin
						w.intp = 1'b1;
						pend_n = RSP_BLOCKED;
						pend_n.outcome = OC_RECORDED;
					end
					cmd.wdata = w;
				end else if (rd.mode != PM_IDLE || r_q.peer == cid) begin
					pend_n = RSP_REJECT;
				end else if (r_q.mode == MODE_SEND) begin
					if (!(32'(r_q.peer) >= NPROC || r_q.peer == PEER_ANY
							|| r_q.peer == PEER_INT)) begin
						cmd.raddr = AW'(r_q.peer);
						st_n      = S_RP;
					end
				end else if (32'(r_q.peer) >= NPROC && r_q.peer != PEER_ANY
						&& r_q.peer != PEER_INT) begin
					pend_n = RSP_REJECT;
				end else if (rd.intp && (r_q.peer == PEER_ANY || r_q.peer == PEER_INT)) begin
					w.intp    = 1'b0;
					cmd.we    = 1'b1;
					cmd.wdata = w;
					pend_n = '{outcome: OC_NOTICE, copy_dst_ref: r_q.msg_ref, copy_src_ref: 32'd0,
						msg_source: PEER_INT, woken_valid: 1'b0, woken_pid: 4'd0};
				end else if (r_q.peer == PEER_ANY && 32'(rd.head) < NPROC) begin
					from_n    = rd.head;
					any_n     = 1'b1;
					cmd.raddr = AW'(rd.head);
					st_n      = S_RF;
				end else if (r_q.peer != PEER_ANY && r_q.peer != PEER_INT) begin
					from_n    = r_q.peer;
					any_n     = 1'b0;
					cmd.raddr = AW'(r_q.peer);
					st_n      = S_RF;
				end else begin
					w.mode    = PM_RECV;
					w.wsrc    = r_q.peer;
					w.ref_h   = r_q.msg_ref;
					cmd.we    = 1'b1;
					cmd.wdata = w;
					pend_n    = RSP_BLOCKED;
				end
			end
			S_RP: begin
				p_n    = rd;
				cmd.we = 1'b1;
				if (rd.mode == PM_RECV && (rd.wsrc == cid || rd.wsrc == PEER_ANY)) begin
					cmd.waddr = AW'(r_q.peer);
					cmd.wdata = clear_rec(rd);
					pend_n = '{outcome: OC_DELIVERED, copy_dst_ref: rd.ref_h,
						copy_src_ref: r_q.msg_ref, msg_source: cid, woken_valid: 1'b1,
						woken_pid: r_q.peer[3:0]};
					st_n = S_FIN;
				end else begin
					w         = c_q;
					w.mode    = PM_SEND;
					w.target  = r_q.peer[3:0];
					w.ref_h   = r_q.msg_ref;
					w.link    = NONE_MARK;
					cmd.waddr = AW'(r_q.caller);
					cmd.wdata = w;
					pend_n    = RSP_BLOCKED;
					if (32'(rd.head) >= NPROC) begin
						st_n = S_HEAD;
					end else begin
						cmd.raddr = AW'(rd.head);
						cur_n     = rd.head;
						st_n      = S_WALK;
					end
				end
			end
			S_HEAD: begin
				w         = p_q;
				w.head    = cid;
				cmd.we    = 1'b1;
				cmd.waddr = AW'(r_q.peer);
				cmd.wdata = w;
				st_n      = S_FIN;
			end
			S_WALK: begin
				if (32'(rd.link) >= NPROC) begin
					w.link    = cid;
					cmd.we    = 1'b1;
					cmd.waddr = AW'(cur_q);
					cmd.wdata = w;
					st_n      = S_FIN;
				end else begin
					cmd.raddr = AW'(rd.link);
					cur_n     = rd.link;
				end
			end
			S_RF: begin
				cmd.we = 1'b1;
				st_n   = S_FIN;
				if (any_q || (rd.mode == PM_SEND && rd.target == r_q.caller)) begin
					w         = clear_rec(rd);
					w.link    = NONE_MARK;
					cmd.waddr = AW'(from_q);
					cmd.wdata = w;
					flink_n   = rd.link;
					pend_n = '{outcome: OC_DELIVERED, copy_dst_ref: r_q.msg_ref,
						copy_src_ref: rd.ref_h, msg_source: from_q, woken_valid: 1'b1,
						woken_pid: from_q[3:0]};
					if (c_q.head == from_q) begin
						st_n = S_UH;
					end else if (32'(c_q.head) < NPROC) begin
						cmd.raddr = AW'(c_q.head);
						cur_n     = c_q.head;
						st_n      = S_UW;
					end
				end else begin
					w         = c_q;
					w.mode    = PM_RECV;
					w.wsrc    = r_q.peer;
					w.ref_h   = r_q.msg_ref;
					cmd.waddr = AW'(r_q.caller);
					cmd.wdata = w;
					pend_n    = RSP_BLOCKED;
				end
			end
			S_UH: begin
				w         = c_q;
				w.head    = flink_q;
				cmd.we    = 1'b1;
				cmd.waddr = AW'(r_q.caller);
				cmd.wdata = w;
				st_n      = S_FIN;
			end
			S_UW: begin
				if (rd.link == from_q) begin
					w.link    = flink_q;
					cmd.we    = 1'b1;
					cmd.waddr = AW'(cur_q);
					cmd.wdata = w;
					st_n      = S_FIN;
				end else if (32'(rd.link) >= NPROC) begin
					st_n = S_FIN;
				end else begin
					cmd.raddr = AW'(rd.link);
					cur_n     = rd.link;
				end
			end
			S_FIN: begin
				if (!vld_q || rsp_ready) begin
					rsp_n = pend_q;
					vld_n = 1'b1;
					st_n  = S_IDLE;
				end
			end
			default: st_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			vld_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			st_q    <= st_n;
			vld_q   <= vld_n;
			any_q   <= any_n;
			r_q     <= r_n;
			c_q     <= c_n;
			p_q     <= p_n;
			cur_q   <= cur_n;
			from_q  <= from_n;
			flink_q <= flink_n;
			pend_q  <= pend_n;
			rsp_q   <= rsp_n;
		end
	end

endmodule

// File: rtl/core/message_rendezvous_unit.sv
// Top level of the message rendezvous unit.
// One request is worked at a time; each gives exactly one result. A send
// that joins a non-empty wait list, or a receive that unlinks a named sender
// from behind the head of its list, walks that list one sender at a time.
// All per-process state sits behind a store with one write port and one
// registered read port. A finished result waits in the output register
// while the next request is taken; the last cycle of a request stalls while
// that register still holds an untaken result.
module message_rendezvous_unit #(
	parameter int NPROC = mru_pkg::NPROC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mru_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mru_pkg::rsp_t rsp
);
	import mru_pkg::*;

	cmd_t cmd;
	rec_t rd;

	mru_ctrl #(.NPROC(NPROC)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.rd        (rd)
	);

	mru_store #(.NPROC(NPROC)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd     (rd)
	);

`ifndef SYNTH
	a_outcome_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.outcome <= OC_REJECTED)
		else $error("outcome code out of range");

	a_wake_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.woken_valid) |->
		(rsp.outcome == OC_DELIVERED || rsp.outcome == OC_NOTICE))
		else $error("wakeup without a delivery");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while busy");
`endif

endmodule
